>>> hdl/acu_pkg.sv
`default_nettype none
package acu_pkg;

  typedef enum logic [5:0] {
    CMD_LDA, CMD_LDX, CMD_LDY, CMD_STA, CMD_STX, CMD_STY, CMD_TAX, CMD_TAY,
    CMD_TXA, CMD_TYA, CMD_TSX, CMD_TXS, CMD_ADC, CMD_SBC, CMD_AND, CMD_ORA,
    CMD_EOR, CMD_CMP, CMD_CPX, CMD_CPY, CMD_INC, CMD_INX, CMD_INY, CMD_DEC,
    CMD_DEX, CMD_DEY, CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR, CMD_JMP, CMD_JSR,
    CMD_RTS, CMD_BPL, CMD_BMI, CMD_BVC, CMD_BVS, CMD_BCC, CMD_BCS, CMD_BNE,
    CMD_BEQ, CMD_CLC, CMD_SEC, CMD_CLI, CMD_SEI, CMD_CLV, CMD_CLD, CMD_SED,
    CMD_PHA, CMD_PLA, CMD_PHP, CMD_PLP, CMD_BRK, CMD_RTI, CMD_BIT, CMD_NOP
  } acu_cmd_e;

  localparam int unsigned FL_C = 0;
  localparam int unsigned FL_Z = 1;
  localparam int unsigned FL_I = 2;
  localparam int unsigned FL_D = 3;
  localparam int unsigned FL_B = 4;
  localparam int unsigned FL_U = 5;
  localparam int unsigned FL_V = 6;
  localparam int unsigned FL_N = 7;

  localparam logic [7:0]  STACK_PAGE_HI = 8'h01;
  localparam logic [7:0]  SP_RESET      = 8'hFD;
  localparam logic [7:0]  STATUS_RESET  = 8'h24;
  localparam logic [15:0] IRQ_VEC_RESET = 16'h0000;
  localparam int unsigned MAX_WRITES    = 3;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] p;
  } acu_arch_t;

  typedef struct packed {
    logic [1:0]                       wr_count;
    logic [MAX_WRITES-1:0][15:0]      wr_addr;
    logic [MAX_WRITES-1:0][7:0]       wr_data;
    logic [15:0]                      next_pc;
    acu_arch_t                        arch;
  } acu_bundle_t;

  function automatic logic [7:0] set_zn(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] r;
    r = p;
    r[FL_Z] = (v == 8'h00);
    r[FL_N] = v[7];
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/acu_exec.sv
`default_nettype none
module acu_exec import acu_pkg::*; (
  input  wire logic [5:0]  cmd_i,
  input  wire logic        on_accumulator_i,
  input  wire logic [7:0]  operand_i,
  input  wire logic [15:0] effective_address_i,
  input  wire logic [15:0] pc_after_fetch_i,
  input  wire logic [23:0] popped_bytes_i,
  input  wire logic [15:0] irq_vector_i,
  input  wire acu_arch_t   arch_i,
  output acu_bundle_t      bundle_o
);

  acu_cmd_e    cmd;
  acu_arch_t   nxt;
  logic [7:0]  m, p0, p1, p2;
  logic [7:0]  sp_m1, sp_m2;
  logic [8:0]  sum9;
  logic [7:0]  add_m, add_r;
  logic [7:0]  cmp_reg;
  logic [8:0]  diff9;
  logic [7:0]  sh_v, sh_r;
  logic        sh_co;
  logic [7:0]  inc_r, dec_r;
  logic [15:0] ret_jsr, ret_brk, rts_pc;
  logic        take;

  assign cmd   = acu_cmd_e'(cmd_i);
  assign m     = operand_i;
  assign p0    = popped_bytes_i[7:0];
  assign p1    = popped_bytes_i[15:8];
  assign p2    = popped_bytes_i[23:16];
  assign sp_m1 = arch_i.sp - 8'd1;
  assign sp_m2 = arch_i.sp - 8'd2;

  assign add_m = (cmd == CMD_SBC) ? ~m : m;
  assign sum9  = {1'b0, arch_i.a} + {1'b0, add_m} + {8'd0, arch_i.p[FL_C]};
  assign add_r = sum9[7:0];

  assign inc_r   = m + 8'd1;
  assign dec_r   = m - 8'd1;
  assign ret_jsr = pc_after_fetch_i - 16'd1;
  assign ret_brk = pc_after_fetch_i + 16'd1;
  assign rts_pc  = {p1, p0} + 16'd1;

  always_comb begin
    case (cmd)
      CMD_CPX: cmp_reg = arch_i.x;
      CMD_CPY: cmp_reg = arch_i.y;
      default: cmp_reg = arch_i.a;
    endcase
  end
  assign diff9 = {1'b0, cmp_reg} - {1'b0, m};

  assign sh_v = on_accumulator_i ? arch_i.a : m;
  always_comb begin
    case (cmd)
      CMD_ASL: begin
        sh_r  = {sh_v[6:0], 1'b0};
        sh_co = sh_v[7];
      end
      CMD_LSR: begin
        sh_r  = {1'b0, sh_v[7:1]};
        sh_co = sh_v[0];
      end
      CMD_ROL: begin
        sh_r  = {sh_v[6:0], arch_i.p[FL_C]};
        sh_co = sh_v[7];
      end
      CMD_ROR: begin
        sh_r  = {arch_i.p[FL_C], sh_v[7:1]};
        sh_co = sh_v[0];
      end
      default: begin
        sh_r  = sh_v;
        sh_co = arch_i.p[FL_C];
      end
    endcase
  end

  always_comb begin
    nxt      = arch_i;
    bundle_o = '0;
    bundle_o.next_pc = pc_after_fetch_i;
    take     = 1'b0;
    case (cmd)
      CMD_LDA: begin
        nxt.a = m;
        nxt.p = set_zn(arch_i.p, m);
      end
      CMD_LDX: begin
        nxt.x = m;
        nxt.p = set_zn(arch_i.p, m);
      end
      CMD_LDY: begin
        nxt.y = m;
        nxt.p = set_zn(arch_i.p, m);
      end
      CMD_STA, CMD_STX, CMD_STY: begin
        bundle_o.wr_count   = 2'd1;
        bundle_o.wr_addr[0] = effective_address_i;
        bundle_o.wr_data[0] = (cmd == CMD_STA) ? arch_i.a :
                              (cmd == CMD_STX) ? arch_i.x : arch_i.y;
      end
      CMD_TAX: begin
        nxt.x = arch_i.a;
        nxt.p = set_zn(arch_i.p, arch_i.a);
      end
      CMD_TAY: begin
        nxt.y = arch_i.a;
        nxt.p = set_zn(arch_i.p, arch_i.a);
      end
      CMD_TXA: begin
        nxt.a = arch_i.x;
        nxt.p = set_zn(arch_i.p, arch_i.x);
      end
      CMD_TYA: begin
        nxt.a = arch_i.y;
        nxt.p = set_zn(arch_i.p, arch_i.y);
      end
      CMD_TSX: begin
        nxt.x = arch_i.sp;
        nxt.p = set_zn(arch_i.p, arch_i.sp);
      end
      CMD_TXS: nxt.sp = arch_i.x;
      CMD_ADC, CMD_SBC: begin
        nxt.a       = add_r;
        nxt.p       = set_zn(arch_i.p, add_r);
        nxt.p[FL_C] = sum9[8];
        nxt.p[FL_V] = (arch_i.a[7] ^ add_r[7]) & (add_m[7] ^ add_r[7]);
      end
      CMD_AND: begin
        nxt.a = arch_i.a & m;
        nxt.p = set_zn(arch_i.p, arch_i.a & m);
      end
      CMD_ORA: begin
        nxt.a = arch_i.a | m;
        nxt.p = set_zn(arch_i.p, arch_i.a | m);
      end
      CMD_EOR: begin
        nxt.a = arch_i.a ^ m;
        nxt.p = set_zn(arch_i.p, arch_i.a ^ m);
      end
      CMD_CMP, CMD_CPX, CMD_CPY: begin
        nxt.p[FL_C] = ~diff9[8];
        nxt.p[FL_Z] = (cmp_reg == m);
        nxt.p[FL_N] = diff9[7];
      end
      CMD_INC: begin
        bundle_o.wr_count   = 2'd1;
        bundle_o.wr_addr[0] = effective_address_i;
        bundle_o.wr_data[0] = inc_r;
        nxt.p = set_zn(arch_i.p, inc_r);
      end
      CMD_DEC: begin
        bundle_o.wr_count   = 2'd1;
        bundle_o.wr_addr[0] = effective_address_i;
        bundle_o.wr_data[0] = dec_r;
        nxt.p = set_zn(arch_i.p, dec_r);
      end
      CMD_INX: begin
        nxt.x = arch_i.x + 8'd1;
        nxt.p = set_zn(arch_i.p, arch_i.x + 8'd1);
      end
      CMD_INY: begin
        nxt.y = arch_i.y + 8'd1;
        nxt.p = set_zn(arch_i.p, arch_i.y + 8'd1);
      end
      CMD_DEX: begin
        nxt.x = arch_i.x - 8'd1;
        nxt.p = set_zn(arch_i.p, arch_i.x - 8'd1);
      end
      CMD_DEY: begin
        nxt.y = arch_i.y - 8'd1;
        nxt.p = set_zn(arch_i.p, arch_i.y - 8'd1);
      end
      CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR: begin
        nxt.p       = set_zn(arch_i.p, sh_r);
        nxt.p[FL_C] = sh_co;
        if (on_accumulator_i) begin
          nxt.a = sh_r;
        end else begin
          bundle_o.wr_count   = 2'd1;
          bundle_o.wr_addr[0] = effective_address_i;
          bundle_o.wr_data[0] = sh_r;
        end
      end
      CMD_JMP: bundle_o.next_pc = effective_address_i;
      CMD_JSR: begin
        bundle_o.wr_count   = 2'd2;
        bundle_o.wr_addr[0] = {STACK_PAGE_HI, arch_i.sp};
        bundle_o.wr_data[0] = ret_jsr[15:8];
        bundle_o.wr_addr[1] = {STACK_PAGE_HI, sp_m1};
        bundle_o.wr_data[1] = ret_jsr[7:0];
        nxt.sp              = sp_m2;
        bundle_o.next_pc    = effective_address_i;
      end
      CMD_RTS: begin
        nxt.sp           = arch_i.sp + 8'd2;
        bundle_o.next_pc = rts_pc;
      end
      CMD_BPL: take = ~arch_i.p[FL_N];
      CMD_BMI: take = arch_i.p[FL_N];
      CMD_BVC: take = ~arch_i.p[FL_V];
      CMD_BVS: take = arch_i.p[FL_V];
      CMD_BCC: take = ~arch_i.p[FL_C];
      CMD_BCS: take = arch_i.p[FL_C];
      CMD_BNE: take = ~arch_i.p[FL_Z];
      CMD_BEQ: take = arch_i.p[FL_Z];
      CMD_CLC: nxt.p[FL_C] = 1'b0;
      CMD_SEC: nxt.p[FL_C] = 1'b1;
      CMD_CLI: nxt.p[FL_I] = 1'b0;
      CMD_SEI: nxt.p[FL_I] = 1'b1;
      CMD_CLV: nxt.p[FL_V] = 1'b0;
      CMD_CLD: nxt.p[FL_D] = 1'b0;
      CMD_SED: nxt.p[FL_D] = 1'b1;
      CMD_PHA, CMD_PHP: begin
        bundle_o.wr_count   = 2'd1;
        bundle_o.wr_addr[0] = {STACK_PAGE_HI, arch_i.sp};
        bundle_o.wr_data[0] = (cmd == CMD_PHA) ? arch_i.a :
                              (arch_i.p | 8'h30);
        nxt.sp              = sp_m1;
      end
      CMD_PLA: begin
        nxt.sp = arch_i.sp + 8'd1;
        nxt.a  = p0;
        nxt.p  = set_zn(arch_i.p, p0);
      end
      CMD_PLP: begin
        nxt.sp       = arch_i.sp + 8'd1;
        nxt.p        = p0;
        nxt.p[FL_B]  = 1'b0;
        nxt.p[FL_U]  = 1'b1;
      end
      CMD_BRK: begin
        bundle_o.wr_count   = 2'd3;
        bundle_o.wr_addr[0] = {STACK_PAGE_HI, arch_i.sp};
        bundle_o.wr_data[0] = ret_brk[15:8];
        bundle_o.wr_addr[1] = {STACK_PAGE_HI, sp_m1};
        bundle_o.wr_data[1] = ret_brk[7:0];
        bundle_o.wr_addr[2] = {STACK_PAGE_HI, sp_m2};
        bundle_o.wr_data[2] = arch_i.p | 8'h30;
        nxt.sp              = arch_i.sp - 8'd3;
        nxt.p[FL_I]         = 1'b1;
        bundle_o.next_pc    = irq_vector_i;
      end
      CMD_RTI: begin
        nxt.sp           = arch_i.sp + 8'd3;
        nxt.p            = p0;
        nxt.p[FL_B]      = 1'b0;
        nxt.p[FL_U]      = 1'b1;
        bundle_o.next_pc = {p2, p1};
      end
      CMD_BIT: begin
        nxt.p[FL_Z] = ((arch_i.a & m) == 8'h00);
        nxt.p[FL_V] = m[6];
        nxt.p[FL_N] = m[7];
      end
      default: ;
    endcase
    if (take) begin
      bundle_o.next_pc = effective_address_i;
    end
    bundle_o.arch = nxt;
  end

endmodule
`default_nettype wire

>>> hdl/accumulator_cpu_execute_unit.sv
// execute stage of an 8-bit accumulator cpu, binary arithmetic only
// input channel: in_valid_i / in_stall_o with one decoded operation per item,
// its operand, effective address, pc after fetch and three stack bytes
// output channel: out_valid_o / out_stall_i, one item per memory write
// (jsr two, brk three, other writers one) or a single item with
// write_enable_o low; last_o marks the final item of an operation
// cfg_we_i / cfg_wdata_i load the brk vector at any edge with cfg_we_i high
// registers update when an operation is taken, so the next one may follow in
// the very next cycle; results of each operation are held in a two-entry
// result buffer and are presented once the results ahead of them are sent
// throughput: one operation per cycle while each gives one item and the
// output is not stalled; an operation with k writes gives k output items
// in_stall_o is decoded from the buffer count: it is high only while both
// entries are full, so one more operation is taken behind a stalled item
// reset: a, x, y cleared, sp 0xfd, status 0x24, vector 0, buffer empty
`default_nettype none
module accumulator_cpu_execute_unit import acu_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [5:0]  cmd_i,
  input  wire logic        on_accumulator_i,
  input  wire logic [7:0]  operand_i,
  input  wire logic [15:0] effective_address_i,
  input  wire logic [15:0] pc_after_fetch_i,
  input  wire logic [23:0] popped_bytes_i,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             write_enable_o,
  output logic [15:0]      write_address_o,
  output logic [7:0]       write_data_o,
  output logic [15:0]      next_pc_o,
  output logic [7:0]       reg_a_o,
  output logic [7:0]       reg_x_o,
  output logic [7:0]       reg_y_o,
  output logic [7:0]       reg_sp_o,
  output logic [7:0]       reg_status_o,
  output logic             last_o
);

  acu_arch_t   arch_q;
  logic [15:0] irq_vec_q;
  acu_bundle_t exec_bundle;
  acu_bundle_t buf_q [2];
  acu_bundle_t head;
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q, cnt_d;
  logic [1:0]  k_q;
  logic [1:0]  nres;
  logic        in_take, out_take, pop;

  acu_exec u_exec (
    .cmd_i               (cmd_i),
    .on_accumulator_i    (on_accumulator_i),
    .operand_i           (operand_i),
    .effective_address_i (effective_address_i),
    .pc_after_fetch_i    (pc_after_fetch_i),
    .popped_bytes_i      (popped_bytes_i),
    .irq_vector_i        (irq_vec_q),
    .arch_i              (arch_q),
    .bundle_o            (exec_bundle)
  );

  assign in_stall_o = (cnt_q == 2'd2);
  assign in_take    = in_valid_i & ~in_stall_o;

  assign head     = buf_q[rd_ptr_q];
  assign nres     = (head.wr_count == 2'd0) ? 2'd1 : head.wr_count;
  assign last_o   = (k_q == nres - 2'd1);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_take = out_valid_o & ~out_stall_i;
  assign pop      = out_take & last_o;

  assign write_enable_o  = (k_q < head.wr_count);
  assign write_address_o = write_enable_o ? head.wr_addr[k_q] : 16'h0000;
  assign write_data_o    = write_enable_o ? head.wr_data[k_q] : 8'h00;
  assign next_pc_o       = head.next_pc;
  assign reg_a_o         = head.arch.a;
  assign reg_x_o         = head.arch.x;
  assign reg_y_o         = head.arch.y;
  assign reg_sp_o        = head.arch.sp;
  assign reg_status_o    = head.arch.p;

  always_comb begin
    cnt_d = cnt_q;
    if (in_take && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!in_take && pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arch_q    <= '{a: 8'h00, x: 8'h00, y: 8'h00, sp: SP_RESET, p: STATUS_RESET};
      irq_vec_q <= IRQ_VEC_RESET;
      wr_ptr_q  <= 1'b0;
      rd_ptr_q  <= 1'b0;
      cnt_q     <= 2'd0;
      k_q       <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        irq_vec_q <= cfg_wdata_i;
      end
      if (in_take) begin
        arch_q   <= exec_bundle.arch;
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (out_take) begin
        if (last_o) begin
          k_q      <= 2'd0;
          rd_ptr_q <= ~rd_ptr_q;
        end else begin
          k_q <= k_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      buf_q[wr_ptr_q] <= exec_bundle;
    end
  end

endmodule
`default_nettype wire

>>> hdl/acu_checker.sv
`default_nettype none
module acu_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        write_enable_o,
  input wire logic [15:0] write_address_o,
  input wire logic [7:0]  write_data_o,
  input wire logic [15:0] next_pc_o,
  input wire logic [7:0]  reg_a_o,
  input wire logic [7:0]  reg_sp_o,
  input wire logic [7:0]  reg_status_o,
  input wire logic        last_o
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(write_address_o)
      && $stable(next_pc_o) && $stable(last_o))
    else $error("stalled output item changed");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_enable_o |-> write_address_o == 16'h0000
      && write_data_o == 8'h00 && last_o)
    else $error("item without write carries address or data");

  a_multi_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> write_enable_o)
    else $error("non-final item without a write");

  a_same_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o && write_enable_o
      && $stable(next_pc_o) && $stable(reg_a_o) && $stable(reg_sp_o)
      && $stable(reg_status_o))
    else $error("items of one operation disagree");

endmodule

bind accumulator_cpu_execute_unit acu_checker u_acu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .write_enable_o  (write_enable_o),
  .write_address_o (write_address_o),
  .write_data_o    (write_data_o),
  .next_pc_o       (next_pc_o),
  .reg_a_o         (reg_a_o),
  .reg_sp_o        (reg_sp_o),
  .reg_status_o    (reg_status_o),
  .last_o          (last_o)
);
`default_nettype wire
